// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bxde_pkg.sv -----
`timescale 1ns / 1ps

package bxde_pkg;

   localparam int MAX_VECTOR_LENGTH = 256;
   localparam int ENTRY_BYTES       = 4;
   localparam int MASK_BITS         = 8;

   localparam int ADDR_W   = $clog2(MAX_VECTOR_LENGTH);
   localparam int POS_W    = $clog2(MAX_VECTOR_LENGTH + 1);
   localparam int WORD_W   = 16;
   localparam int VLEN_W   = 9;
   localparam int BLOG_W   = 4;
   localparam int BLKNUM_W = 7;
   localparam int COUNT_W  = 8;
   localparam int TOTAL_W  = 10;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int MAX_BLOG   = 8;

   localparam logic [VLEN_W-1:0] VLEN_RESET = 9'd128;
   localparam logic [BLOG_W-1:0] BLOG_RESET = 4'd3;

   // op codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SLICE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LOG2    = 1'd1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LENGTH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_REF = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

   // result tdata layout
   localparam int RSP_DATA_W   = 48;
   localparam int RSP_EV_BIT   = 16;
   localparam int RSP_BN_LSB   = 17;
   localparam int RSP_BM_LSB   = 24;
   localparam int RSP_TB_LSB   = 32;
   localparam int RSP_ST_LSB   = 42;

   typedef struct packed {
      logic                  active;      // slice word inside the vector
      logic                  clear_pre;   // vector aborted by a kind switch
      logic                  clear_post;  // vector ends with this item
      logic                  close;       // last word of its block
      logic                  window;      // word's flag survives in the mask
      logic                  tb_en;       // good final slice word
      logic [STATUS_W-1:0]   status;
      logic [BLKNUM_W-1:0]   block_number;
      logic [WORD_W-1:0]     word;
      logic                  last;
   } stage_type;

endpackage

// ----- src/block_xor_delta_encoder.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake           | Content
// req     | in  | req_tvalid/tready   | tdata word_value, tuser op, tlast last_word
// rsp     | out | rsp_tvalid/tready   | tdata result fields, tlast vector_done
// csr     | in  | csr_valid/ready     | csr_index register, csr_data value
//
// One item per cycle sustained unless a result stalls or a register write waits.
// The front stage reads the reference memory (single port, registered read); the
// back stage compares, updates the block mask and loads the output register.
// Reset is synchronous: no item in flight, 128-word vectors, 8-word blocks.
// A stalled result holds; req_tready drops when a register write waits or both
// stages are full and the result stalls; csr_ready drops while the stage is full.

module block_xor_delta_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // word_value[15:0]
   input  logic        req_tuser,   // op
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // decoded_word[15:0], entry_valid[16], block_number[23:17], block_mask[31:24],
   // total_bytes[41:32], status[43:42], zero[47:44]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,   // vector_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam int PW = bxde_pkg::POS_W;

   // configuration
   logic [bxde_pkg::VLEN_W-1:0] vlen_ff;
   logic [bxde_pkg::BLOG_W-1:0] blog_ff;

   // front state
   logic          ref_valid_ff, ref_valid_in;
   logic [PW-1:0] pos_count_ff, pos_count_in;
   logic          kind_ff;

   // back state
   logic [bxde_pkg::MASK_BITS-1:0] mask_ff, mask_in;
   logic                           has_diff_ff, has_diff_in;
   logic [bxde_pkg::COUNT_W-1:0]   entry_count_ff, entry_count_in;

   // pipeline
   bxde_pkg::stage_type          stage_ff, stage_in;
   logic                         stage_valid_ff;
   logic [bxde_pkg::WORD_W-1:0]  ref_rd_ff;
   logic [bxde_pkg::WORD_W-1:0]  ref_mem [bxde_pkg::MAX_VECTOR_LENGTH];

   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff;
   logic        rsp_last_ff;

   logic req_accept, csr_write, advance, out_free;
   logic mem_we, mem_re;

   // front combinational
   logic [PW-1:0]   len, pos, blk;
   logic [PW:0]     blk_end, pos_next;
   logic [3:0]      bb;
   logic            abort, ref_ok, in_range, good_len;

   // back combinational
   logic            diff;
   logic [bxde_pkg::MASK_BITS-1:0] m0, m1;
   logic            h0, h1;
   logic [bxde_pkg::COUNT_W-1:0]   e0, e1;
   logic [bxde_pkg::WORD_W-1:0]    decoded;
   logic            ev;
   logic [bxde_pkg::BLKNUM_W-1:0]  bn;
   logic [bxde_pkg::MASK_BITS-1:0] bm;
   logic [bxde_pkg::TOTAL_W-1:0]   tb;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = stage_valid_ff && out_free;
   // hold new items while a register write waits for the stage to drain
   assign req_tready = (!stage_valid_ff || advance) && !csr_valid;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = !stage_valid_ff;
   assign csr_write  = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- front stage ----------------
   always_comb begin
      if (vlen_ff == '0) begin
         len = PW'(1);
      end else if ((PW+1)'(vlen_ff) > (PW+1)'(bxde_pkg::MAX_VECTOR_LENGTH)) begin
         len = PW'(bxde_pkg::MAX_VECTOR_LENGTH);
      end else begin
         len = PW'(vlen_ff);
      end
      if (blog_ff == '0) begin
         bb = 4'd1;
      end else if (blog_ff > 4'(bxde_pkg::MAX_BLOG)) begin
         bb = 4'(bxde_pkg::MAX_BLOG);
      end else begin
         bb = blog_ff;
      end

      abort    = (pos_count_ff != '0) && (req_tuser != kind_ff);
      pos      = abort ? '0 : pos_count_ff;
      ref_ok   = (abort && kind_ff == bxde_pkg::OP_LOAD) ? 1'b0 : ref_valid_ff;
      in_range = pos < len;
      pos_next = (PW+1)'(pos) + (PW+1)'(1);
      good_len = pos_next == (PW+1)'(len);

      blk     = pos >> bb;
      blk_end = ((PW+1)'(blk) + (PW+1)'(1)) << bb;
      if (blk_end > (PW+1)'(len)) begin
         blk_end = (PW+1)'(len);
      end

      stage_in              = '0;
      stage_in.clear_pre    = abort;
      stage_in.last         = req_tlast;
      stage_in.word         = req_tdata;
      stage_in.block_number = blk[bxde_pkg::BLKNUM_W-1:0];
      stage_in.close        = pos_next == blk_end;
      stage_in.window       = (blk_end - pos_next) < (PW+1)'(bxde_pkg::MASK_BITS);
      stage_in.status       = bxde_pkg::ST_OK;

      ref_valid_in = ref_ok;
      pos_count_in = pos;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      if (req_tuser == bxde_pkg::OP_LOAD) begin
         if (pos == '0) begin
            ref_valid_in = 1'b0;
         end
         mem_we = in_range;
         if (req_tlast) begin
            stage_in.clear_post = 1'b1;
            pos_count_in        = '0;
            if (good_len) begin
               ref_valid_in = 1'b1;
            end else begin
               stage_in.status = bxde_pkg::ST_LENGTH;
            end
         end else if (in_range) begin
            pos_count_in = pos_next[PW-1:0];
         end
      end else if (!ref_ok) begin
         stage_in.status = bxde_pkg::ST_NO_REF;
      end else begin
         stage_in.active = in_range;
         mem_re          = in_range;
         if (req_tlast) begin
            stage_in.clear_post = 1'b1;
            pos_count_in        = '0;
            if (good_len) begin
               stage_in.tb_en = 1'b1;
            end else begin
               stage_in.status = bxde_pkg::ST_LENGTH;
            end
         end else if (in_range) begin
            pos_count_in = pos_next[PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && mem_we) begin
         ref_mem[pos[bxde_pkg::ADDR_W-1:0]] <= req_tdata;
      end
      if (req_accept && mem_re) begin
         ref_rd_ff <= ref_mem[pos[bxde_pkg::ADDR_W-1:0]];
      end
   end

   // ---------------- back stage ----------------
   always_comb begin
      m0 = stage_ff.clear_pre ? '0 : mask_ff;
      h0 = stage_ff.clear_pre ? 1'b0 : has_diff_ff;
      e0 = stage_ff.clear_pre ? '0 : entry_count_ff;

      diff = stage_ff.word != ref_rd_ff;
      m1   = m0;
      h1   = h0;
      e1   = e0;

      decoded = '0;
      ev      = 1'b0;
      bn      = '0;
      bm      = '0;
      tb      = '0;

      if (stage_ff.active) begin
         m1      = {m0[bxde_pkg::MASK_BITS-2:0], diff};
         h1      = h0 | diff;
         decoded = (diff && stage_ff.window) ? stage_ff.word : ref_rd_ff;
         if (stage_ff.close) begin
            if (h1) begin
               ev = 1'b1;
               bn = stage_ff.block_number;
               bm = m1;
               e1 = e0 + bxde_pkg::COUNT_W'(1);
            end
            m1 = '0;
            h1 = 1'b0;
         end
      end
      if (stage_ff.tb_en) begin
         tb = bxde_pkg::TOTAL_W'(e1 * bxde_pkg::ENTRY_BYTES);
      end

      mask_in        = stage_ff.clear_post ? '0 : m1;
      has_diff_in    = stage_ff.clear_post ? 1'b0 : h1;
      entry_count_in = stage_ff.clear_post ? '0 : e1;

      rsp_data_in = {4'd0, stage_ff.status, tb, bm, bn, ev, decoded};
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff        <= bxde_pkg::VLEN_RESET;
         blog_ff        <= bxde_pkg::BLOG_RESET;
         ref_valid_ff   <= 1'b0;
         pos_count_ff   <= '0;
         kind_ff        <= bxde_pkg::OP_LOAD;
         mask_ff        <= '0;
         has_diff_ff    <= 1'b0;
         entry_count_ff <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            ref_valid_ff <= ref_valid_in;
            pos_count_ff <= pos_count_in;
            kind_ff      <= req_tuser;
         end
         if (advance) begin
            mask_ff        <= mask_in;
            has_diff_ff    <= has_diff_in;
            entry_count_ff <= entry_count_in;
         end
         // writes arrive only while idle: drop any vector in progress
         if (csr_write) begin
            pos_count_ff   <= '0;
            mask_ff        <= '0;
            has_diff_ff    <= 1'b0;
            entry_count_ff <= '0;
            unique case (csr_index)
               bxde_pkg::CSR_VECTOR_LENGTH: begin
                  vlen_ff      <= csr_data[bxde_pkg::VLEN_W-1:0];
                  ref_valid_ff <= 1'b0;
               end
               bxde_pkg::CSR_BLOCK_LOG2: begin
                  blog_ff <= csr_data[bxde_pkg::BLOG_W-1:0];
               end
               default: begin
               end
            endcase
         end
         stage_valid_ff <= req_accept || (stage_valid_ff && !advance);
         rsp_valid_ff   <= advance || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= stage_ff.last;
      end
   end

endmodule

// ----- src/bxde_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bxde_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic [1:0] st;
   logic [9:0] tb;
   logic [7:0] bm;
   logic [6:0] bn;
   logic       ev;

   assign st = rsp_tdata[bxde_pkg::RSP_ST_LSB +: bxde_pkg::STATUS_W];
   assign tb = rsp_tdata[bxde_pkg::RSP_TB_LSB +: bxde_pkg::TOTAL_W];
   assign bm = rsp_tdata[bxde_pkg::RSP_BM_LSB +: bxde_pkg::MASK_BITS];
   assign bn = rsp_tdata[bxde_pkg::RSP_BN_LSB +: bxde_pkg::BLKNUM_W];
   assign ev = rsp_tdata[bxde_pkg::RSP_EV_BIT];

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // a missing reference never produces an entry or an unused status code
   `ASSERT_IMPLIES(a_status_code, clock, reset, rsp_tvalid && (ev || st == bxde_pkg::ST_UNUSED),
      st != bxde_pkg::ST_NO_REF && st != bxde_pkg::ST_UNUSED, "bad status with result")

   // byte total only on a good end of vector
   `ASSERT_IMPLIES(a_total_end, clock, reset, rsp_tvalid && tb != '0,
      rsp_tlast && st == bxde_pkg::ST_OK, "byte total off the final word")

   // without an entry, number and mask stay zero
   `ASSERT_IMPLIES(a_no_entry, clock, reset, rsp_tvalid && !ev,
      bm == '0 && bn == '0, "entry fields set without entry")

endmodule

bind block_xor_delta_encoder bxde_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
